// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// cond holds at every edge out of reset
`define AWFS_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// ante implies cons in the same cycle
`define AWFS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// ante implies cons in the next cycle
`define AWFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define AWFS_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define AWFS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define AWFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hdl/awfs_pkg.sv =====
// ----------------------------------------------------------------------------
// awfs_pkg
// Types and constants for the area-weighted face smoothing block.
// ----------------------------------------------------------------------------
package awfs_pkg;

  localparam int MAX_GROUP_DEF  = 16;
  localparam int COORD_BITS_DEF = 16;

  localparam int COORD_W    = 16;   // input coordinate field width
  localparam int QUAL_W     = 24;   // quality width, Q8.16
  localparam int AREA_W     = 40;   // area accumulator width
  localparam int WSUM_W     = 64;   // weighted sum width
  localparam int MULW       = 26;   // shared multiplier operand width
  localparam int AREA_SPLIT = 20;   // area split into two chunks for area*quality
  localparam int QUO_W      = 25;   // quotient bits resolved by the divider

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] MUL_LAST  = 4'd15;
  localparam logic [STEP_W-1:0] PROD_LAST = 4'd2;

  localparam logic [AREA_W-1:0]        AREA_MAX = {AREA_W{1'b1}};
  localparam logic signed [QUAL_W-1:0] Q_MAX    = 24'sh7FFFFF;
  localparam logic signed [QUAL_W-1:0] Q_MIN    = 24'sh800000;
  localparam logic [QUO_W-1:0]         QUO_POS_LIM = 25'h07FFFFF;
  localparam logic [QUO_W-1:0]         QUO_NEG_LIM = 25'h0800000;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_ZERO_AREA = 2'd1,
    STAT_OVERFLOW  = 2'd2
  } awfs_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SQRT,
    S_PROD,
    S_ACC,
    S_FIN,
    S_DIV,
    S_OUT
  } awfs_state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vert_a_x;
    logic signed [COORD_W-1:0] vert_a_y;
    logic signed [COORD_W-1:0] vert_a_z;
    logic signed [COORD_W-1:0] vert_b_x;
    logic signed [COORD_W-1:0] vert_b_y;
    logic signed [COORD_W-1:0] vert_b_z;
    logic signed [COORD_W-1:0] vert_c_x;
    logic signed [COORD_W-1:0] vert_c_y;
    logic signed [COORD_W-1:0] vert_c_z;
    logic signed [QUAL_W-1:0]  face_quality;
    logic                      last_in_group;
  } awfs_in_t;

  typedef struct packed {
    logic signed [QUAL_W-1:0] smoothed_quality;
    logic [AREA_W-1:0]        group_area;
    logic [1:0]               status;
  } awfs_out_t;

endpackage

// ===== hdl/awfs_stream_if.sv =====
// ----------------------------------------------------------------------------
// awfs_stream_if
// Valid/ready stream channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface awfs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/area_weighted_face_smoothing.sv =====
// ----------------------------------------------------------------------------
// area_weighted_face_smoothing
// Per triangle: cross product and squared length on the shared 26x26 multiplier, a square root
// (one root bit per cycle), then area*quality and accumulation; input is ready only while idle.
// A beat beyond MAX_GROUP is not accumulated, only flagged as overflow. On the last beat a divider
// resolves the quotient unless overflow, zero area or saturation skips it; the result is registered.
// Synchronous reset clears the accumulators, the sequencer and the output valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module area_weighted_face_smoothing
  import awfs_pkg::*;
#(
  parameter int MAX_GROUP  = MAX_GROUP_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  awfs_stream_if.sink   face_in,
  awfs_stream_if.source result_out
);

  localparam int EW   = COORD_BITS + 1;          // edge width
  localparam int PW   = 2 * EW;                  // edge product / cross magnitude width
  localparam int XW   = PW + 1;                  // cross component width
  localparam int SW   = 2 * PW;                  // squared length width
  localparam int RW   = PW;                      // root width
  localparam int RXW  = (RW > AREA_W) ? RW : AREA_W + 1;
  localparam int CBX  = (COORD_BITS > COORD_W) ? COORD_BITS : COORD_W;
  localparam int CNTW = $clog2(MAX_GROUP + 1);
  localparam int SQCW = $clog2(RW);
  localparam int DVCW = $clog2(QUO_W);

  function automatic logic signed [EW-1:0] coord_ext(input logic [COORD_W-1:0] f);
    logic [CBX-1:0] z;
    z = CBX'(f);
    return {z[COORD_BITS-1], z[COORD_BITS-1:0]};
  endfunction

  // control
  awfs_state_t       state, state_next;
  logic [STEP_W-1:0] step;
  logic [SQCW-1:0]   sq_cnt;
  logic [DVCW-1:0]   div_cnt;
  logic              in_ready, accept, out_load, out_valid;

  // accumulators
  logic [AREA_W-1:0]        area_total;
  logic signed [WSUM_W-1:0] weighted_total;
  logic [CNTW-1:0]          items_seen;
  logic                     overflow_seen;

  // per-item datapath
  logic signed [EW-1:0]     ux, uy, uz, vx, vy, vz;
  logic signed [QUAL_W-1:0] qual;
  logic                     last, skip;
  logic signed [MULW-1:0]   mul_a, mul_b;
  logic signed [2*MULW-1:0] mul_p;
  logic signed [PW-1:0]     cross_tmp;
  logic [PW-1:0]            mag_x, mag_y, mag_z;
  logic [SW-1:0]            sq_sum;
  logic [RW+1:0]            sq_rem;
  logic [RW-1:0]            root;
  logic signed [WSUM_W-1:0] wprod;

  // final division
  awfs_status_t        res_status;
  logic                w_neg, div_sat, div_big;
  logic [AREA_W-1:0]   div_rem;
  logic [QUO_W-1:0]    div_low, quo;
  awfs_out_t           out_reg, res_item;

  // ---------------------------------------------------------------- decode
  assign accept = face_in.valid && in_ready;

  always_comb begin
    unique case (state)
      S_IDLE:  state_next = accept ?
                 ((items_seen >= CNTW'(MAX_GROUP)) ? S_ACC : S_MUL) : S_IDLE;
      S_MUL:   state_next = (step == MUL_LAST) ? S_SQRT : S_MUL;
      S_SQRT:  state_next = (sq_cnt == SQCW'(RW - 1)) ? S_PROD : S_SQRT;
      S_PROD:  state_next = (step == PROD_LAST) ? S_ACC : S_PROD;
      S_ACC:   state_next = last ? S_FIN : S_IDLE;
      S_FIN:   state_next = (overflow_seen || area_total == '0 || div_big) ? S_OUT : S_DIV;
      S_DIV:   state_next = (div_cnt == DVCW'(QUO_W - 1)) ? S_OUT : S_DIV;
      S_OUT:   state_next = out_load ? S_IDLE : S_OUT;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == S_IDLE);
    out_load = (state == S_OUT) && (!out_valid || result_out.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      step    <= '0;
      sq_cnt  <= '0;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      step  <= ((state == S_MUL || state == S_PROD) && state_next == state) ?
               step + 1'b1 : '0;
      sq_cnt  <= (state == S_SQRT) ? sq_cnt + 1'b1 : '0;
      div_cnt <= (state == S_DIV) ? div_cnt + 1'b1 : '0;
    end
  end

  // ------------------------------------------------------ shared multiplier
  logic [EW-1:0]         hx, lx, hy, ly, hz, lz;
  logic [RXW-1:0]        root_half;
  logic [AREA_W-1:0]     tri_area;

  assign hx = mag_x[PW-1:EW];
  assign lx = mag_x[EW-1:0];
  assign hy = mag_y[PW-1:EW];
  assign ly = mag_y[EW-1:0];
  assign hz = mag_z[PW-1:EW];
  assign lz = mag_z[EW-1:0];

  assign root_half = RXW'(root) >> 1;
  assign tri_area  = (|root_half[RXW-1:AREA_W]) ? AREA_MAX : root_half[AREA_W-1:0];

  function automatic logic signed [MULW-1:0] sx(input logic signed [EW-1:0] v);
    return {{(MULW-EW){v[EW-1]}}, v};
  endfunction

  function automatic logic signed [MULW-1:0] zx(input logic [EW-1:0] v);
    return {{(MULW-EW){1'b0}}, v};
  endfunction

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_MUL) begin
      unique case (step)
        4'd0:    begin mul_a = sx(uy); mul_b = sx(vz); end
        4'd1:    begin mul_a = sx(uz); mul_b = sx(vy); end
        4'd2:    begin mul_a = sx(uz); mul_b = sx(vx); end
        4'd3:    begin mul_a = sx(ux); mul_b = sx(vz); end
        4'd4:    begin mul_a = sx(ux); mul_b = sx(vy); end
        4'd5:    begin mul_a = sx(uy); mul_b = sx(vx); end
        4'd6:    begin mul_a = zx(hx); mul_b = zx(hx); end
        4'd7:    begin mul_a = zx(hx); mul_b = zx(lx); end
        4'd8:    begin mul_a = zx(lx); mul_b = zx(lx); end
        4'd9:    begin mul_a = zx(hy); mul_b = zx(hy); end
        4'd10:   begin mul_a = zx(hy); mul_b = zx(ly); end
        4'd11:   begin mul_a = zx(ly); mul_b = zx(ly); end
        4'd12:   begin mul_a = zx(hz); mul_b = zx(hz); end
        4'd13:   begin mul_a = zx(hz); mul_b = zx(lz); end
        4'd14:   begin mul_a = zx(lz); mul_b = zx(lz); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state == S_PROD) begin
      mul_b = {{(MULW-QUAL_W){qual[QUAL_W-1]}}, qual};
      mul_a = (step == '0) ?
              {{(MULW-AREA_SPLIT){1'b0}}, tri_area[AREA_SPLIT-1:0]} :
              {{(MULW-AREA_SPLIT){1'b0}}, tri_area[AREA_W-1:AREA_SPLIT]};
    end
  end

  // ----------------------------------------------------------- datapath math
  logic signed [XW-1:0]     cross_diff;
  logic [XW-1:0]            cross_neg;
  logic [PW-1:0]            cross_mag, part;
  logic [RW+1:0]            rem_sh, trial;
  logic signed [WSUM_W-1:0] prod_ext;
  logic [AREA_W:0]          area_sum;
  logic signed [WSUM_W-1:0] w_sum;
  logic                     w_ovf;
  logic [WSUM_W-1:0]        w_mag, num;
  logic [AREA_W:0]          dv_sh, dv_diff;
  logic                     dv_ge;

  always_comb begin
    cross_diff = {mul_p[PW-1], mul_p[PW-1:0]};
    cross_diff = {cross_tmp[PW-1], cross_tmp} - cross_diff;
    cross_neg  = -cross_diff;
    cross_mag  = cross_diff[XW-1] ? cross_neg[PW-1:0] : cross_diff[PW-1:0];
    part       = mul_p[PW-1:0];

    rem_sh = {sq_rem[RW-1:0], sq_sum[SW-1 -: 2]};
    trial  = {root, 2'b01};

    prod_ext = {{(WSUM_W-2*MULW){mul_p[2*MULW-1]}}, mul_p};

    area_sum = {1'b0, area_total} + {1'b0, tri_area};
    w_sum    = weighted_total + wprod;
    // same-sign operands giving a result of the other sign
    w_ovf    = (weighted_total[WSUM_W-1] == wprod[WSUM_W-1]) &&
               (w_sum[WSUM_W-1] != weighted_total[WSUM_W-1]);

    // rounded magnitude numerator: |w| + area/2
    w_mag   = weighted_total[WSUM_W-1] ? -weighted_total : weighted_total;
    num     = w_mag + WSUM_W'(area_total >> 1);
    div_big = {1'b0, num[WSUM_W-1:QUO_W]} >= area_total;

    dv_sh   = {div_rem, div_low[QUO_W-1]};
    dv_diff = dv_sh - {1'b0, area_total};
    dv_ge   = dv_sh >= {1'b0, area_total};
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          ux     <= coord_ext(face_in.payload.vert_b_x) - coord_ext(face_in.payload.vert_a_x);
          uy     <= coord_ext(face_in.payload.vert_b_y) - coord_ext(face_in.payload.vert_a_y);
          uz     <= coord_ext(face_in.payload.vert_b_z) - coord_ext(face_in.payload.vert_a_z);
          vx     <= coord_ext(face_in.payload.vert_c_x) - coord_ext(face_in.payload.vert_a_x);
          vy     <= coord_ext(face_in.payload.vert_c_y) - coord_ext(face_in.payload.vert_a_y);
          vz     <= coord_ext(face_in.payload.vert_c_z) - coord_ext(face_in.payload.vert_a_z);
          qual   <= face_in.payload.face_quality;
          last   <= face_in.payload.last_in_group;
          skip   <= (items_seen >= CNTW'(MAX_GROUP));
          sq_sum <= '0;
        end
      end
      S_MUL: begin
        // each step consumes the product issued in the previous step
        unique case (step)
          4'd1, 4'd3, 4'd5:   cross_tmp <= mul_p[PW-1:0];
          4'd2:               mag_x <= cross_mag;
          4'd4:               mag_y <= cross_mag;
          4'd6:               mag_z <= cross_mag;
          4'd7, 4'd10, 4'd13: sq_sum <= sq_sum + {part, {PW{1'b0}}};
          4'd8, 4'd11, 4'd14: sq_sum <= sq_sum + (SW'(part) << (EW + 1));
          4'd9, 4'd12, 4'd15: sq_sum <= sq_sum + SW'(part);
          default: ;
        endcase
        if (step == MUL_LAST) begin
          sq_rem <= '0;
          root   <= '0;
        end
      end
      S_SQRT: begin
        sq_sum <= sq_sum << 2;
        if (rem_sh >= trial) begin
          sq_rem <= rem_sh - trial;
          root   <= {root[RW-2:0], 1'b1};
        end else begin
          sq_rem <= rem_sh;
          root   <= {root[RW-2:0], 1'b0};
        end
      end
      S_PROD: begin
        if (step == 4'd1) begin
          wprod <= prod_ext;
        end else if (step == PROD_LAST) begin
          wprod <= wprod + (prod_ext <<< AREA_SPLIT);
        end
      end
      S_FIN: begin
        w_neg   <= weighted_total[WSUM_W-1];
        div_sat <= div_big;
        div_rem <= {1'b0, num[WSUM_W-1:QUO_W]};
        div_low <= num[QUO_W-1:0];
        quo     <= '0;
        if (overflow_seen) begin
          res_status <= STAT_OVERFLOW;
        end else if (area_total == '0) begin
          res_status <= STAT_ZERO_AREA;
        end else begin
          res_status <= STAT_OK;
        end
      end
      S_DIV: begin
        div_low <= div_low << 1;
        div_rem <= dv_ge ? dv_diff[AREA_W-1:0] : dv_sh[AREA_W-1:0];
        quo     <= {quo[QUO_W-2:0], dv_ge};
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------ accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      area_total     <= '0;
      weighted_total <= '0;
      items_seen     <= '0;
      overflow_seen  <= 1'b0;
    end else if (state == S_ACC) begin
      if (skip) begin
        overflow_seen <= 1'b1;
      end else begin
        area_total     <= area_sum[AREA_W] ? AREA_MAX : area_sum[AREA_W-1:0];
        weighted_total <= !w_ovf ? w_sum :
                          weighted_total[WSUM_W-1] ? {1'b1, {(WSUM_W-1){1'b0}}} :
                                                     {1'b0, {(WSUM_W-1){1'b1}}};
        items_seen     <= items_seen + 1'b1;
      end
    end else if (out_load) begin
      area_total     <= '0;
      weighted_total <= '0;
      items_seen     <= '0;
      overflow_seen  <= 1'b0;
    end
  end

  // ------------------------------------------------------------------ result
  always_comb begin
    res_item.status           = res_status;
    res_item.smoothed_quality = '0;
    res_item.group_area       = '0;
    if (res_status == STAT_OK) begin
      res_item.group_area = area_total;
      priority if (div_sat) begin
        res_item.smoothed_quality = w_neg ? Q_MIN : Q_MAX;
      end else if (!w_neg) begin
        res_item.smoothed_quality = (quo > QUO_POS_LIM) ? Q_MAX : quo[QUAL_W-1:0];
      end else begin
        res_item.smoothed_quality = (quo > QUO_NEG_LIM) ? Q_MIN : -quo[QUAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_reg <= res_item;
    end
  end

  assign face_in.ready      = in_ready;
  assign result_out.valid   = out_valid;
  assign result_out.payload = out_reg;

  // -------------------------------------------------------------- assertions
  `AWFS_ASSERT_NEXT(a_busy_after_beat, clk, rst, face_in.valid && face_in.ready, !face_in.ready, "input ready right after a beat")
  `AWFS_ASSERT_ALWAYS(a_count_bound, clk, rst, items_seen <= CNTW'(MAX_GROUP), "group count past limit")
  `AWFS_ASSERT_IMPLIES(a_ovf_full, clk, rst, overflow_seen, items_seen == CNTW'(MAX_GROUP), "overflow with group not full")
  `AWFS_ASSERT_IMPLIES(a_sqrt_rem, clk, rst, state == S_SQRT, (sq_rem >> 1) <= root, "root remainder out of bound")
  `AWFS_ASSERT_IMPLIES(a_div_rem, clk, rst, state == S_DIV, div_rem < area_total, "divider remainder not below divisor")

endmodule
